### design/sedt_pkg.sv
// shared types, constants and the multiply-accumulate microprogram for the sharp edge test
`timescale 1ns / 1ps
package sedt_pkg;

  localparam int COORD_W = 16;
  localparam int VIDX_W = 12;
  localparam int TIDX_W = 13;
  localparam int DIFF_W = 17;
  localparam int NRM_W = 35;
  localparam int LIMB_W = 34;
  localparam int PROD_W = 2 * LIMB_W;
  localparam int SQ_W = 68;
  localparam int DOT_W = 69;
  localparam int T_W = 3 * LIMB_W;
  localparam int ACC_W = 170;
  localparam int SH_W = 7;
  localparam int NSTEPS = 34;
  localparam int STEP_W = 6;
  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_MAX_TRIANGLES = 8192;
  localparam logic signed [COORD_W-1:0] COS_RESET = -16'sd28378;

  typedef enum logic [1:0] {
    OP_LOAD_VERTEX   = 2'd0,
    OP_LOAD_TRIANGLE = 2'd1,
    OP_TEST_EDGE     = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRI1, ST_TRI2, ST_TRI3, ST_VRD, ST_DIFF, ST_RUN, ST_DECIDE
  } state_t;

  typedef enum logic [4:0] {
    SRC_A0, SRC_A1, SRC_A2, SRC_B0, SRC_B1, SRC_B2, SRC_C0, SRC_C1, SRC_C2,
    SRC_N10, SRC_N11, SRC_N12, SRC_N20, SRC_N21, SRC_N22,
    SRC_N1SQ0, SRC_N1SQ1, SRC_N2SQ0, SRC_N2SQ1, SRC_MAG0, SRC_MAG1,
    SRC_T0, SRC_T1, SRC_T2, SRC_COS, SRC_CSQ
  } opnd_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_N10, DST_N11, DST_N12, DST_N20, DST_N21, DST_N22,
    DST_N1SQ, DST_N2SQ, DST_DOT, DST_CSQ, DST_T
  } dst_t;

  typedef struct packed {
    opnd_t           opa;
    opnd_t           opb;
    logic [SH_W-1:0] sh;
    logic            neg;
    logic            first;
    dst_t            dst;
  } ustep_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic   issue;
    ustep_t step;
  } mac_ctl_t;

  typedef struct packed {
    logic fin_neg;
    logic fin_zero;
    logic dot_neg;
    logic n1_zero;
    logic n2_zero;
  } mac_stat_t;

  function automatic ustep_t mk(opnd_t a, opnd_t b, int sh, logic neg, logic first,
                                dst_t dst);
    ustep_t s;
    s.opa = a;
    s.opb = b;
    s.sh = SH_W'(sh);
    s.neg = neg;
    s.first = first;
    s.dst = dst;
    return s;
  endfunction

  // a = p2-p1, b = p4-p1, c = p3-p1; n1 = a x b, n2 = c x a
  // final accumulator holds dot^2 * 2^30 - n1sq * n2sq * cos^2
  function automatic ustep_t ustep(logic [STEP_W-1:0] idx);
    ustep_t s;
    case (idx)
      6'd0:  s = mk(SRC_COS, SRC_COS, 0, 1'b0, 1'b1, DST_CSQ);
      6'd1:  s = mk(SRC_A1, SRC_B2, 0, 1'b0, 1'b1, DST_NONE);
      6'd2:  s = mk(SRC_A2, SRC_B1, 0, 1'b1, 1'b0, DST_N10);
      6'd3:  s = mk(SRC_A2, SRC_B0, 0, 1'b0, 1'b1, DST_NONE);
      6'd4:  s = mk(SRC_A0, SRC_B2, 0, 1'b1, 1'b0, DST_N11);
      6'd5:  s = mk(SRC_A0, SRC_B1, 0, 1'b0, 1'b1, DST_NONE);
      6'd6:  s = mk(SRC_A1, SRC_B0, 0, 1'b1, 1'b0, DST_N12);
      6'd7:  s = mk(SRC_C1, SRC_A2, 0, 1'b0, 1'b1, DST_NONE);
      6'd8:  s = mk(SRC_C2, SRC_A1, 0, 1'b1, 1'b0, DST_N20);
      6'd9:  s = mk(SRC_C2, SRC_A0, 0, 1'b0, 1'b1, DST_NONE);
      6'd10: s = mk(SRC_C0, SRC_A2, 0, 1'b1, 1'b0, DST_N21);
      6'd11: s = mk(SRC_C0, SRC_A1, 0, 1'b0, 1'b1, DST_NONE);
      6'd12: s = mk(SRC_C1, SRC_A0, 0, 1'b1, 1'b0, DST_N22);
      6'd13: s = mk(SRC_N10, SRC_N10, 0, 1'b0, 1'b1, DST_NONE);
      6'd14: s = mk(SRC_N11, SRC_N11, 0, 1'b0, 1'b0, DST_NONE);
      6'd15: s = mk(SRC_N12, SRC_N12, 0, 1'b0, 1'b0, DST_N1SQ);
      6'd16: s = mk(SRC_N20, SRC_N20, 0, 1'b0, 1'b1, DST_NONE);
      6'd17: s = mk(SRC_N21, SRC_N21, 0, 1'b0, 1'b0, DST_NONE);
      6'd18: s = mk(SRC_N22, SRC_N22, 0, 1'b0, 1'b0, DST_N2SQ);
      6'd19: s = mk(SRC_N10, SRC_N20, 0, 1'b0, 1'b1, DST_NONE);
      6'd20: s = mk(SRC_N11, SRC_N21, 0, 1'b0, 1'b0, DST_NONE);
      6'd21: s = mk(SRC_N12, SRC_N22, 0, 1'b0, 1'b0, DST_DOT);
      6'd22: s = mk(SRC_N2SQ0, SRC_CSQ, 0, 1'b0, 1'b1, DST_NONE);
      6'd23: s = mk(SRC_N2SQ1, SRC_CSQ, LIMB_W, 1'b0, 1'b0, DST_T);
      6'd24: s = mk(SRC_MAG0, SRC_MAG0, 30, 1'b0, 1'b1, DST_NONE);
      6'd25: s = mk(SRC_MAG0, SRC_MAG1, LIMB_W + 30, 1'b0, 1'b0, DST_NONE);
      6'd26: s = mk(SRC_MAG1, SRC_MAG0, LIMB_W + 30, 1'b0, 1'b0, DST_NONE);
      6'd27: s = mk(SRC_MAG1, SRC_MAG1, 2 * LIMB_W + 30, 1'b0, 1'b0, DST_NONE);
      6'd28: s = mk(SRC_N1SQ0, SRC_T0, 0, 1'b1, 1'b0, DST_NONE);
      6'd29: s = mk(SRC_N1SQ0, SRC_T1, LIMB_W, 1'b1, 1'b0, DST_NONE);
      6'd30: s = mk(SRC_N1SQ0, SRC_T2, 2 * LIMB_W, 1'b1, 1'b0, DST_NONE);
      6'd31: s = mk(SRC_N1SQ1, SRC_T0, LIMB_W, 1'b1, 1'b0, DST_NONE);
      6'd32: s = mk(SRC_N1SQ1, SRC_T1, 2 * LIMB_W, 1'b1, 1'b0, DST_NONE);
      6'd33: s = mk(SRC_N1SQ1, SRC_T2, 3 * LIMB_W, 1'b1, 1'b0, DST_NONE);
      default: s = mk(SRC_A0, SRC_A0, 0, 1'b0, 1'b1, DST_NONE);
    endcase
    return s;
  endfunction

endpackage

### design/sedt_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module sedt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sedt_mac.sv
// shared multiply-accumulate unit with the normal, square and dot product registers
`timescale 1ns / 1ps
module sedt_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  sedt_pkg::mac_ctl_t         ctl,
  input  sedt_pkg::dvec_t            da,
  input  sedt_pkg::dvec_t            db,
  input  sedt_pkg::dvec_t            dc,
  input  logic signed [15:0]         cos_limit,
  output sedt_pkg::mac_stat_t        stat
);
  import sedt_pkg::*;

  logic signed [NRM_W-1:0] n1 [3];
  logic signed [NRM_W-1:0] n2 [3];
  logic [SQ_W-1:0]         n1sq;
  logic [SQ_W-1:0]         n2sq;
  logic signed [DOT_W-1:0] dot;
  logic [SQ_W-1:0]         mag;
  logic [LIMB_W-1:0]       csq;
  logic [T_W-1:0]          tv;
  logic [ACC_W-1:0]        acc;

  logic                    pv;
  logic [PROD_W-1:0]       prod;
  logic                    psign;
  logic [SH_W-1:0]         psh;
  logic                    pfirst;
  dst_t                    pdst;

  logic signed [NRM_W-1:0] va, vb;
  logic [LIMB_W-1:0]       ma, mb;
  logic [ACC_W-1:0]        shifted, base, acc_next;

  function automatic logic signed [NRM_W-1:0] pick(opnd_t c);
    logic signed [NRM_W-1:0] v;
    case (c)
      SRC_A0:    v = NRM_W'(da.x);
      SRC_A1:    v = NRM_W'(da.y);
      SRC_A2:    v = NRM_W'(da.z);
      SRC_B0:    v = NRM_W'(db.x);
      SRC_B1:    v = NRM_W'(db.y);
      SRC_B2:    v = NRM_W'(db.z);
      SRC_C0:    v = NRM_W'(dc.x);
      SRC_C1:    v = NRM_W'(dc.y);
      SRC_C2:    v = NRM_W'(dc.z);
      SRC_N10:   v = n1[0];
      SRC_N11:   v = n1[1];
      SRC_N12:   v = n1[2];
      SRC_N20:   v = n2[0];
      SRC_N21:   v = n2[1];
      SRC_N22:   v = n2[2];
      SRC_N1SQ0: v = {1'b0, n1sq[LIMB_W-1:0]};
      SRC_N1SQ1: v = {1'b0, n1sq[2*LIMB_W-1:LIMB_W]};
      SRC_N2SQ0: v = {1'b0, n2sq[LIMB_W-1:0]};
      SRC_N2SQ1: v = {1'b0, n2sq[2*LIMB_W-1:LIMB_W]};
      SRC_MAG0:  v = {1'b0, mag[LIMB_W-1:0]};
      SRC_MAG1:  v = {1'b0, mag[2*LIMB_W-1:LIMB_W]};
      SRC_T0:    v = {1'b0, tv[LIMB_W-1:0]};
      SRC_T1:    v = {1'b0, tv[2*LIMB_W-1:LIMB_W]};
      SRC_T2:    v = {1'b0, tv[3*LIMB_W-1:2*LIMB_W]};
      SRC_COS:   v = NRM_W'(cos_limit);
      SRC_CSQ:   v = {1'b0, csq};
      default:   v = '0;
    endcase
    return v;
  endfunction

  // sign and magnitude, the multiplier is unsigned
  always_comb begin
    va = pick(ctl.step.opa);
    vb = pick(ctl.step.opb);
    ma = va[NRM_W-1] ? LIMB_W'(-va) : LIMB_W'(va);
    mb = vb[NRM_W-1] ? LIMB_W'(-vb) : LIMB_W'(vb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= ctl.issue;
    end
    prod <= ma * mb;
    psign <= va[NRM_W-1] ^ vb[NRM_W-1] ^ ctl.step.neg;
    psh <= ctl.step.sh;
    pfirst <= ctl.step.first;
    pdst <= ctl.step.dst;
  end

  // subtract as add of the complement with carry in
  always_comb begin
    shifted = ACC_W'(prod) << psh;
    base = pfirst ? '0 : acc;
    acc_next = base + (psign ? ~shifted : shifted) + ACC_W'(psign);
  end

  always_ff @(posedge clk) begin
    if (pv) begin
      acc <= acc_next;
      case (pdst)
        DST_N10:  n1[0] <= acc_next[NRM_W-1:0];
        DST_N11:  n1[1] <= acc_next[NRM_W-1:0];
        DST_N12:  n1[2] <= acc_next[NRM_W-1:0];
        DST_N20:  n2[0] <= acc_next[NRM_W-1:0];
        DST_N21:  n2[1] <= acc_next[NRM_W-1:0];
        DST_N22:  n2[2] <= acc_next[NRM_W-1:0];
        DST_N1SQ: n1sq <= acc_next[SQ_W-1:0];
        DST_N2SQ: n2sq <= acc_next[SQ_W-1:0];
        DST_DOT:  dot <= acc_next[DOT_W-1:0];
        DST_CSQ:  csq <= acc_next[LIMB_W-1:0];
        DST_T:    tv <= acc_next[T_W-1:0];
        default: ;
      endcase
    end
    mag <= dot[DOT_W-1] ? SQ_W'(-dot) : SQ_W'(dot);
  end

  always_comb begin
    stat.fin_neg = acc[ACC_W-1];
    stat.fin_zero = (acc == '0);
    stat.dot_neg = dot[DOT_W-1];
    stat.n1_zero = (n1[0] == '0) && (n1[1] == '0) && (n1[2] == '0);
    stat.n2_zero = (n2[0] == '0) && (n2[1] == '0) && (n2[2] == '0);
  end

endmodule

### design/sharp_edge_dihedral_test_core.sv
// Sharp edge test: vertex and triangle stores, a small sequencer and one shared
// multiply-accumulate unit that decides whether the dihedral angle at an edge is sharp.
//
// Input channel (in_valid / in_stall) carries one item per transfer: op 0 writes a
// vertex, op 1 writes a triangle, op 2 tests an edge shared by two triangles.
// Output channel (out_valid / out_stall) carries sharp_start / sharp_end for each edge
// found sharp; a test that is not sharp gives nothing.
// A test that finds both third corners keeps in_stall high through the triangle reads
// (ST_TRI1..3), the four vertex reads (ST_VRD), the differences (ST_DIFF), the shared
// 34x34 multiplier (ST_RUN: 34 micro steps plus the accumulate stage) and the decide
// step (ST_DECIDE). out_valid rises after the decide step, and the next item is taken
// only once the test is done. The multiplier is the bottleneck. cos_limit is written
// through cfg_we / cfg_data; the user must write it only while the block is idle, and
// the block does not enforce it. Reset clears the sequencer, the output valid and
// sets cos_limit to about -cos(30 deg); the stores are not cleared and must be loaded
// before they are read. A result waiting under out_stall does not block new items;
// only a later sharp edge waits in its decide step until the output register is free.
`timescale 1ns / 1ps
module sharp_edge_dihedral_test_core #(
  parameter int MAX_VERTICES = sedt_pkg::DEF_MAX_VERTICES,
  parameter int MAX_TRIANGLES = sedt_pkg::DEF_MAX_TRIANGLES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [12:0] slot_index,
  input  logic [15:0] coord_x,
  input  logic [15:0] coord_y,
  input  logic [15:0] coord_z,
  input  logic [11:0] corner_a,
  input  logic [11:0] corner_b,
  input  logic [11:0] corner_c,
  input  logic [11:0] edge_start,
  input  logic [11:0] edge_end,
  input  logic [12:0] triangle_one,
  input  logic [12:0] triangle_two,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] sharp_start,
  output logic [11:0] sharp_end,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import sedt_pkg::*;

  localparam int VA_W = $clog2(MAX_VERTICES);
  localparam int TA_W = $clog2(MAX_TRIANGLES);

  state_t state, state_next;

  logic signed [15:0] cos_limit;
  logic [VIDX_W-1:0]  e0, e1, ov1, ov2;
  logic [TIDX_W-1:0]  t1, t2;
  logic               found1;
  logic [2:0]         vcnt;
  logic [STEP_W:0]    step_cnt;
  logic [3*COORD_W-1:0] p1, p2, p3, p4;
  dvec_t              da, db, dc;

  logic               accept;
  logic               vram_we, tram_we;
  logic [VA_W-1:0]    vram_raddr;
  logic [TA_W-1:0]    tram_raddr;
  logic [3*COORD_W-1:0] vram_rdata;
  logic [3*VIDX_W-1:0]  tram_rdata;
  logic [VIDX_W:0]    third;
  logic               sharp, out_free;
  mac_ctl_t           mac_ctl;
  mac_stat_t          mac_stat;

  // last corner in a, b, c order that is neither edge vertex, with a found flag on top
  function automatic logic [VIDX_W:0] third_corner(logic [3*VIDX_W-1:0] corners,
                                                   logic [VIDX_W-1:0] s,
                                                   logic [VIDX_W-1:0] t);
    logic [VIDX_W-1:0] ca, cb, cc;
    logic [VIDX_W:0] r;
    ca = corners[VIDX_W-1:0];
    cb = corners[2*VIDX_W-1:VIDX_W];
    cc = corners[3*VIDX_W-1:2*VIDX_W];
    if (cc != s && cc != t) begin
      r = {1'b1, cc};
    end else if (cb != s && cb != t) begin
      r = {1'b1, cb};
    end else if (ca != s && ca != t) begin
      r = {1'b1, ca};
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic dvec_t vdiff(logic [3*COORD_W-1:0] p, logic [3*COORD_W-1:0] q);
    dvec_t d;
    d.x = DIFF_W'(signed'(p[COORD_W-1:0])) - DIFF_W'(signed'(q[COORD_W-1:0]));
    d.y = DIFF_W'(signed'(p[2*COORD_W-1:COORD_W])) -
          DIFF_W'(signed'(q[2*COORD_W-1:COORD_W]));
    d.z = DIFF_W'(signed'(p[3*COORD_W-1:2*COORD_W])) -
          DIFF_W'(signed'(q[3*COORD_W-1:2*COORD_W]));
    return d;
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign vram_we = accept && (op == OP_LOAD_VERTEX) && (32'(slot_index) < MAX_VERTICES);
  assign tram_we = accept && (op == OP_LOAD_TRIANGLE) &&
                   (32'(slot_index) < MAX_TRIANGLES);
  assign third = third_corner(tram_rdata, e0, e1);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (vcnt)
      3'd0:    vram_raddr = VA_W'(e0);
      3'd1:    vram_raddr = VA_W'(e1);
      3'd2:    vram_raddr = VA_W'(ov1);
      default: vram_raddr = VA_W'(ov2);
    endcase
    tram_raddr = (state == ST_TRI1) ? TA_W'(t1) : TA_W'(t2);
  end

  sedt_ram #(.WIDTH(3 * COORD_W), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (VA_W'(slot_index)),
    .wdata ({coord_z, coord_y, coord_x}),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  sedt_ram #(.WIDTH(3 * VIDX_W), .DEPTH(MAX_TRIANGLES)) u_tram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (TA_W'(slot_index)),
    .wdata ({corner_c, corner_b, corner_a}),
    .raddr (tram_raddr),
    .rdata (tram_rdata)
  );

  assign mac_ctl.issue = (state == ST_RUN) && (step_cnt < (STEP_W + 1)'(NSTEPS));
  assign mac_ctl.step = ustep(step_cnt[STEP_W-1:0]);

  sedt_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .da        (da),
    .db        (db),
    .dc        (dc),
    .cos_limit (cos_limit),
    .stat      (mac_stat)
  );

  // sign of dot vs limit, final accumulator is dot^2*2^30 - |n1|^2*|n2|^2*cos^2
  always_comb begin
    if (mac_stat.n1_zero || mac_stat.n2_zero) begin
      sharp = 1'b0;
    end else if (!cos_limit[15]) begin
      sharp = mac_stat.dot_neg || mac_stat.fin_neg;
    end else begin
      sharp = mac_stat.dot_neg && !mac_stat.fin_neg && !mac_stat.fin_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && op == OP_TEST_EDGE && 32'(triangle_one) < MAX_TRIANGLES &&
            32'(triangle_two) < MAX_TRIANGLES && 32'(edge_start) < MAX_VERTICES &&
            32'(edge_end) < MAX_VERTICES) begin
          state_next = ST_TRI1;
        end
      end
      ST_TRI1: state_next = ST_TRI2;
      ST_TRI2: state_next = ST_TRI3;
      ST_TRI3: begin
        if (found1 && third[VIDX_W] && 32'(ov1) < MAX_VERTICES &&
            32'(third[VIDX_W-1:0]) < MAX_VERTICES) begin
          state_next = ST_VRD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_VRD: begin
        if (vcnt == 3'd4) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_RUN;
      ST_RUN: begin
        if (step_cnt == (STEP_W + 1)'(NSTEPS)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!sharp || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_limit <= COS_RESET;
      out_valid <= 1'b0;
      vcnt <= '0;
      step_cnt <= '0;
    end else begin
      if (cfg_we) begin
        cos_limit <= cfg_data;
      end
      if (state == ST_DECIDE && sharp && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      vcnt <= (state == ST_VRD) ? vcnt + 3'd1 : '0;
      step_cnt <= (state == ST_RUN) ? step_cnt + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e0 <= edge_start;
      e1 <= edge_end;
      t1 <= triangle_one;
      t2 <= triangle_two;
    end
    if (state == ST_TRI2) begin
      found1 <= third[VIDX_W];
      ov1 <= third[VIDX_W-1:0];
    end
    if (state == ST_TRI3) begin
      ov2 <= third[VIDX_W-1:0];
    end
    // read data is registered, so it arrives in the cycle after its address
    if (state == ST_VRD) begin
      case (vcnt)
        3'd1:    p1 <= vram_rdata;
        3'd2:    p2 <= vram_rdata;
        3'd3:    p3 <= vram_rdata;
        3'd4:    p4 <= vram_rdata;
        default: ;
      endcase
    end
    if (state == ST_DIFF) begin
      da <= vdiff(p2, p1);
      db <= vdiff(p4, p1);
      dc <= vdiff(p3, p1);
    end
    if (state == ST_DECIDE && sharp && out_free) begin
      sharp_start <= e0;
      sharp_end <= e1;
    end
  end

  a_rise_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DECIDE)
    else $error("output valid rose outside the decide step");

  a_run_to_decide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step_cnt == (STEP_W + 1)'(NSTEPS)) |=> state == ST_DECIDE)
    else $error("micro sequence did not end in the decide step");

  a_no_issue_outside_run: assert property (@(posedge clk) disable iff (rst)
    mac_ctl.issue |-> (state == ST_RUN && !in_stall == 1'b0))
    else $error("multiplier step issued outside the run phase");

endmodule
